### hw/rtl/met_pkg.sv
// Shared types and constants for the mask edge trim block.
// Used by the controller, the datapath and the top level; depends on nothing.

package met_pkg;

   localparam int VALUE_W   = 32;
   localparam int TRIM_W    = 9;
   localparam int DIM_W     = 9;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NULL_VALUE  = 2'd0,
      CSR_TRIM_AMOUNT = 2'd1,
      CSR_FRAME_ROWS  = 2'd2,
      CSR_FRAME_COLS  = 2'd3
   } csr_idx_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_FETCH = 1'b1
   } mode_type;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_wr;    // store the accepted word at the load index
      logic trim_init;  // start the row pass
      logic col_init;   // start the column pass
      logic scan_rd;    // clear the trim count; the store reads the scan address
      logic fwd_step;   // move one pixel forward along the line
      logic bwd_start;  // jump to the far end of the line
      logic bwd_step;   // move one pixel back along the line
      logic null_wr;    // write the null word at the scan address
      logic next_line;  // move to the start of the next line
      logic fetch;      // read the store at the read index
      logic out_load;   // capture read data into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic load_done;
      logic px_set;
      logic fwd_end;
      logic pos_zero;
      logic trim_zero;
      logic fwd_null_end;
      logic bwd_null_end;
      logic line_last;
      logic col_pass;
      logic fetch_last;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/met_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; used for the frame store.

module met_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/met_datapath.sv
// Datapath of the mask edge trim block: registers, frame store, scan counters
// and output register. Depends on met_pkg and met_ram.

module met_datapath import met_pkg::*; #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256,
   localparam int DEPTH   = MAX_ROWS * MAX_COLS,
   localparam int MAX_LEN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS,
   localparam int LW      = $clog2(MAX_LEN + 1),
   localparam int IW      = $clog2(DEPTH + 1),
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]   csr_wr_data,
   input  logic [VALUE_W-1:0]   req_pixel_value,
   input  logic                 rsp_stall,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   output logic [VALUE_W-1:0]   rsp_out_value,
   output logic                 rsp_out_last
);

   logic [VALUE_W-1:0] null_ff;
   logic [TRIM_W-1:0]  trim_ff;
   logic [DIM_W-1:0]   rows_ff;
   logic [DIM_W-1:0]   cols_ff;

   logic [LW-1:0]      eff_rows;
   logic [LW-1:0]      eff_cols;
   logic [2*LW-1:0]    prod;
   logic [IW-1:0]      total;

   logic [IW-1:0]      addr_ff, addr_in;
   logic [IW-1:0]      base_ff, base_in;
   logic [LW-1:0]      pos_ff, pos_in;
   logic [LW-1:0]      line_ff, line_in;
   logic [TRIM_W-1:0]  cnt_ff, cnt_in;
   logic               pass_ff, pass_in;
   logic [IW-1:0]      load_idx_ff, load_idx_in;
   logic [IW-1:0]      read_idx_ff, read_idx_in;
   logic               fetch_last_ff, fetch_last_in;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic [LW-1:0]      len;
   logic [LW-1:0]      nlines;
   logic [IW-1:0]      stride;
   logic [IW-1:0]      line_step;
   logic [IW-1:0]      last_off;

   logic               load_ok;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   logic               fwd_end;
   logic               pos_zero;
   logic               fetch_last;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         null_ff <= '0;
         trim_ff <= '0;
         rows_ff <= DIM_RESET;
         cols_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NULL_VALUE:  null_ff <= csr_wr_data;
            CSR_TRIM_AMOUNT: trim_ff <= csr_wr_data[TRIM_W-1:0];
            CSR_FRAME_ROWS:  rows_ff <= csr_wr_data[DIM_W-1:0];
            CSR_FRAME_COLS:  cols_ff <= csr_wr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp dimensions: zero counts as one, oversize counts as the maximum
   always_comb begin
      if (rows_ff == '0) begin
         eff_rows = LW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         eff_rows = LW'(MAX_ROWS);
      end else begin
         eff_rows = LW'(rows_ff);
      end
      if (cols_ff == '0) begin
         eff_cols = LW'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         eff_cols = LW'(MAX_COLS);
      end else begin
         eff_cols = LW'(cols_ff);
      end
   end

   assign prod  = {{LW{1'b0}}, eff_rows} * {{LW{1'b0}}, eff_cols};
   assign total = prod[IW-1:0];

   // Line geometry: rows walk with stride one, columns with stride of a row
   always_comb begin
      if (pass_ff) begin
         len       = eff_rows;
         nlines    = eff_cols;
         stride    = IW'(eff_cols);
         line_step = IW'(1);
         last_off  = total - IW'(eff_cols);
      end else begin
         len       = eff_cols;
         nlines    = eff_rows;
         stride    = IW'(1);
         line_step = IW'(eff_cols);
         last_off  = IW'(eff_cols) - IW'(1);
      end
   end

   assign fwd_end    = ((LW+1)'(pos_ff) + (LW+1)'(1)) == (LW+1)'(len);
   assign pos_zero   = (pos_ff == '0);
   assign fetch_last = ((IW+1)'(read_idx_ff) + (IW+1)'(1)) >= (IW+1)'(total);
   assign load_ok    = (load_idx_ff < total);

   always_comb begin
      addr_in       = addr_ff;
      base_in       = base_ff;
      pos_in        = pos_ff;
      line_in       = line_ff;
      cnt_in        = cnt_ff;
      pass_in       = pass_ff;
      load_idx_in   = load_idx_ff;
      read_idx_in   = read_idx_ff;
      fetch_last_in = fetch_last_ff;
      if (cmd.trim_init || cmd.col_init) begin
         pass_in = cmd.col_init;
         base_in = '0;
         addr_in = '0;
         pos_in  = '0;
         line_in = '0;
      end
      if (cmd.scan_rd) begin
         cnt_in = '0;
      end
      if (cmd.fwd_step) begin
         pos_in  = pos_ff + LW'(1);
         addr_in = addr_ff + stride;
         cnt_in  = cnt_ff + TRIM_W'(1);
      end
      if (cmd.bwd_start) begin
         pos_in  = len - LW'(1);
         addr_in = base_ff + last_off;
      end
      if (cmd.bwd_step) begin
         pos_in  = pos_ff - LW'(1);
         addr_in = addr_ff - stride;
         cnt_in  = cnt_ff + TRIM_W'(1);
      end
      if (cmd.next_line) begin
         line_in = line_ff + LW'(1);
         base_in = base_ff + line_step;
         addr_in = base_ff + line_step;
         pos_in  = '0;
      end
      if (cmd.load_wr) begin
         load_idx_in = load_idx_ff + IW'(1);
      end
      if (cmd.fetch) begin
         fetch_last_in = fetch_last;
         if (fetch_last) begin
            read_idx_in = '0;
            load_idx_in = '0;
         end else begin
            read_idx_in = read_idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff   <= '0;
         read_idx_ff   <= '0;
         pass_ff       <= 1'b0;
         fetch_last_ff <= 1'b0;
      end else begin
         load_idx_ff   <= load_idx_in;
         read_idx_ff   <= read_idx_in;
         pass_ff       <= pass_in;
         fetch_last_ff <= fetch_last_in;
      end
      addr_ff <= addr_in;
      base_ff <= base_in;
      pos_ff  <= pos_in;
      line_ff <= line_in;
      cnt_ff  <= cnt_in;
   end

   // Frame store
   assign ram_wr_en   = (cmd.load_wr && load_ok) || cmd.null_wr;
   assign ram_wr_addr = cmd.null_wr ? addr_ff[AW-1:0] : load_idx_ff[AW-1:0];
   assign ram_wr_data = cmd.null_wr ? null_ff : req_pixel_value;
   assign ram_rd_addr = cmd.fetch ? read_idx_ff[AW-1:0] : addr_ff[AW-1:0];

   met_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: hold the word until the far side takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_value_ff <= ram_rd_data;
         rsp_last_ff  <= fetch_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

   always_comb begin
      status.load_done    = ((IW+1)'(load_idx_ff) + (IW+1)'(1)) >= (IW+1)'(total);
      status.px_set       = (ram_rd_data != null_ff);
      status.fwd_end      = fwd_end;
      status.pos_zero     = pos_zero;
      status.trim_zero    = (trim_ff == '0);
      status.fwd_null_end = (((TRIM_W+1)'(cnt_ff) + (TRIM_W+1)'(1))
                             >= (TRIM_W+1)'(trim_ff)) || fwd_end;
      status.bwd_null_end = (cnt_ff == trim_ff) || pos_zero;
      status.line_last    = ((LW+1)'(line_ff) + (LW+1)'(1)) == (LW+1)'(nlines);
      status.col_pass     = pass_ff;
      status.fetch_last   = fetch_last_ff;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

endmodule

### hw/rtl/met_ctrl.sv
// Controller of the mask edge trim block: load, trim passes and readout.
// Depends on met_pkg; drives the datapath through cmd_type.

module met_ctrl import met_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_mode,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_LOAD     = 10'b0000000001,
      S_FWD_RD   = 10'b0000000010,
      S_FWD_CMP  = 10'b0000000100,
      S_FWD_NULL = 10'b0000001000,
      S_BWD_RD   = 10'b0000010000,
      S_BWD_CMP  = 10'b0000100000,
      S_BWD_NULL = 10'b0001000000,
      S_READY    = 10'b0010000000,
      S_FETCH    = 10'b0100000000,
      S_SPARE    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      line_done;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      line_done = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_stall = 1'b0;
            // fetches here are taken and dropped
            if (req_valid && req_mode == MODE_LOAD) begin
               cmd.load_wr = 1'b1;
               if (status.load_done) begin
                  cmd.trim_init = 1'b1;
                  state_in      = S_FWD_RD;
               end
            end
         end
         S_FWD_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_FWD_CMP;
         end
         S_FWD_CMP: begin
            if (status.px_set) begin
               if (status.trim_zero) begin
                  cmd.bwd_start = 1'b1;
                  state_in      = S_BWD_RD;
               end else begin
                  state_in = S_FWD_NULL;
               end
            end else if (status.fwd_end) begin
               // empty line: the backward search would find nothing either
               line_done = 1'b1;
            end else begin
               cmd.fwd_step = 1'b1;
               state_in     = S_FWD_RD;
            end
         end
         S_FWD_NULL: begin
            cmd.null_wr = 1'b1;
            if (status.fwd_null_end) begin
               cmd.bwd_start = 1'b1;
               state_in      = S_BWD_RD;
            end else begin
               cmd.fwd_step = 1'b1;
            end
         end
         S_BWD_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_BWD_CMP;
         end
         S_BWD_CMP: begin
            if (status.px_set) begin
               state_in = S_BWD_NULL;
            end else if (status.pos_zero) begin
               line_done = 1'b1;
            end else begin
               cmd.bwd_step = 1'b1;
               state_in     = S_BWD_RD;
            end
         end
         S_BWD_NULL: begin
            cmd.null_wr = 1'b1;
            if (status.bwd_null_end) begin
               line_done = 1'b1;
            end else begin
               cmd.bwd_step = 1'b1;
            end
         end
         S_READY: begin
            req_stall = !status.out_free;
            // loads here are taken and dropped
            if (req_valid && status.out_free && req_mode == MODE_FETCH) begin
               cmd.fetch = 1'b1;
               state_in  = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.out_load = 1'b1;
            state_in     = status.fetch_last ? S_LOAD : S_READY;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (line_done) begin
         if (status.line_last) begin
            if (status.col_pass) begin
               state_in = S_READY;
            end else begin
               cmd.col_init = 1'b1;
               state_in     = S_FWD_RD;
            end
         end else begin
            cmd.next_line = 1'b1;
            state_in      = S_FWD_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/mask_edge_trim.sv
// Top level of the mask edge trim block.
// Depends on met_pkg, met_ctrl and met_datapath.

// Loads one frame of 32-bit words in row-major order, one word per cycle, then
// stalls the request side while it trims: for every row it nulls the leading
// set pixel and trim_amount-1 pixels after it (none if trim_amount is zero),
// then the trailing set pixel and trim_amount pixels before it, and afterwards
// does the same for every column. Each pass walks the single-port-read frame
// store: each pixel examined takes a registered read, then a compare, and each
// pixel nulled takes a write; a search stops at the first set pixel. Readout
// then returns one word per fetch (store read, output register). Loads while
// the trimmed frame is waiting and fetches before it is ready are taken and
// dropped. The store is not cleared after reset.

module mask_edge_trim import met_pkg::*; #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]   csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [VALUE_W-1:0]   req_pixel_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VALUE_W-1:0]   rsp_out_value,
   output logic                 rsp_out_last
);

   cmd_type    cmd;
   status_type status;

   met_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   met_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_pixel_value (req_pixel_value),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_last    (rsp_out_last)
   );

endmodule

### hw/rtl/met_checker.sv
// Port-level checks for the mask edge trim block, bound to its top level.
// Depends on met_pkg for field widths.

module met_checker import met_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_mode,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [VALUE_W-1:0] rsp_out_value,
   input logic               rsp_out_last
);

   // Reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word visible after reset");

   // A new result word follows an accepted fetch, via the fetch state and the output register
   a_word_from_fetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !($past(rsp_valid) && $past(rsp_stall)))
         |-> $past(req_valid && !req_stall && req_mode == MODE_FETCH, 2))
      else $error("result word without a fetch");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result word dropped");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_out_value) && $stable(rsp_out_last)))
      else $error("stalled result word changed");

endmodule

bind mask_edge_trim met_checker u_met_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for mask_edge_trim: loads frames, predicts the trimmed readout
// and checks every returned word. Depends on met_pkg and the mask_edge_trim RTL only.

module tb import met_pkg::*; ();

   localparam int STORE_WORDS   = 256 * 256;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      mode_type           mode;
      logic [VALUE_W-1:0] pixel;
      int unsigned        gap;
   } req_word_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               last;
   } px_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VALUE_W-1:0]   csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_mode = 1'b0;
   logic [VALUE_W-1:0]   req_pixel_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VALUE_W-1:0]   rsp_out_value;
   logic                 rsp_out_last;

   // register copies and frame state of the predictor
   logic [VALUE_W-1:0]   null_word = '0;
   logic [TRIM_W-1:0]    trim_len = '0;
   logic [DIM_W-1:0]     rows_reg = DIM_RESET;
   logic [DIM_W-1:0]     cols_reg = DIM_RESET;
   logic [VALUE_W-1:0]   frame_mem [STORE_WORDS];
   int unsigned          ld_idx = 0;
   int unsigned          rd_idx = 0;
   bit                   frame_ready = 1'b0;

   req_word_type         pixel_q[$];
   px_word_type          trimmed_q[$];
   req_word_type         nxt;
   px_word_type          exp_w;
   int unsigned          words_sent = 0;
   int unsigned          words_taken = 0;
   int unsigned          gap_done = 0;
   int unsigned          stall_left = 0;
   int unsigned          snd_max = 14;
   int unsigned          rcv_max = 14;
   int unsigned          err_count = 0;
   bit                   hold_go = 1'b0;
   bit                   hold_taken = 1'b0;
   int unsigned          hold_left = 0;

   mask_edge_trim dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_last    (rsp_out_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned dim_in_use(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function automatic int unsigned frame_size();
      return dim_in_use(rows_reg) * dim_in_use(cols_reg);
   endfunction

   // Row pass, then column pass, each from the leading and then the trailing edge.
   function automatic void trim_frame();
      int unsigned rows, cols, t, r, c, k, stop;
      rows = dim_in_use(rows_reg);
      cols = dim_in_use(cols_reg);
      t = trim_len;
      for (r = 0; r < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            if (frame_mem[r * cols + c] != null_word) begin
               stop = (c + t > cols) ? cols : c + t;
               for (k = c; k < stop; k++) frame_mem[r * cols + k] = null_word;
               break;
            end
         end
         for (c = cols; c > 0; c--) begin
            if (frame_mem[r * cols + c - 1] != null_word) begin
               stop = (c - 1 >= t) ? c - 1 - t : 0;
               for (k = stop; k < c; k++) frame_mem[r * cols + k] = null_word;
               break;
            end
         end
      end
      for (c = 0; c < cols; c++) begin
         for (r = 0; r < rows; r++) begin
            if (frame_mem[r * cols + c] != null_word) begin
               stop = (r + t > rows) ? rows : r + t;
               for (k = r; k < stop; k++) frame_mem[k * cols + c] = null_word;
               break;
            end
         end
         for (r = rows; r > 0; r--) begin
            if (frame_mem[(r - 1) * cols + c] != null_word) begin
               stop = (r - 1 >= t) ? r - 1 - t : 0;
               for (k = stop; k < r; k++) frame_mem[k * cols + c] = null_word;
               break;
            end
         end
      end
   endfunction

   // Advance the predicted frame state by one accepted word.
   function automatic void take_word(logic mode, logic [VALUE_W-1:0] pix);
      int unsigned total;
      px_word_type res;
      total = frame_size();
      if (mode == MODE_LOAD) begin
         if (!frame_ready) begin
            if (ld_idx < total) frame_mem[ld_idx] = pix;
            ld_idx++;
            if (ld_idx >= total) begin
               trim_frame();
               frame_ready = 1'b1;
               rd_idx = 0;
            end
         end
      end else if (frame_ready) begin
         res.value = frame_mem[rd_idx];
         res.last = (rd_idx + 1 >= total);
         trimmed_q = {trimmed_q, res};
         if (res.last) begin
            frame_ready = 1'b0;
            ld_idx = 0;
            rd_idx = 0;
         end else begin
            rd_idx++;
         end
      end
   endfunction

   // Request driver: each word waits out its own gap before it is offered.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_done = 0;
      end else begin
         if (req_valid && !req_stall) begin
            take_word(req_mode, req_pixel_value);
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pixel_q.size() != 0 && gap_done < pixel_q[0].gap) begin
               gap_done++;
               req_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
               nxt = pixel_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= nxt.mode;
               req_pixel_value <= nxt.pixel;
               gap_done = 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started by the first result once armed.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (hold_go && rsp_valid && !hold_taken) begin
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor and receiver stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (trimmed_q.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected word: value %h last %b", rsp_out_value, rsp_out_last);
            end else begin
               exp_w = trimmed_q.pop_front();
               if (rsp_out_value !== exp_w.value || rsp_out_last !== exp_w.last) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("mismatch: expected value %h last %b, got value %h last %b",
                              exp_w.value, exp_w.last, rsp_out_value, rsp_out_last);
               end
            end
            stall_left = $urandom_range(0, rcv_max);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0) || (hold_left > 1);
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [VALUE_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_NULL_VALUE:  null_word = data;
         CSR_TRIM_AMOUNT: trim_len = data[TRIM_W-1:0];
         CSR_FRAME_ROWS:  rows_reg = data[DIM_W-1:0];
         CSR_FRAME_COLS:  cols_reg = data[DIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_word(mode_type m, logic [VALUE_W-1:0] p);
      req_word_type w;
      w.mode = m;
      w.pixel = p;
      w.gap = $urandom_range(0, snd_max);
      pixel_q = {pixel_q, w};
      words_sent++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0, 1, 2: return null_word;
         3:       return null_word ^ (32'd1 << $urandom_range(0, 31));
         4:       return ~null_word;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_loads(int unsigned n);
      repeat (n) push_word(MODE_LOAD, pick_pixel());
   endtask

   task automatic push_fetches(int unsigned n);
      repeat (n) push_word(MODE_FETCH, $urandom);
   endtask

   // Hold the sender until every word is taken and every result is back.
   task automatic drain();
      do @(negedge clock);
      while (words_taken != words_sent || trimmed_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_pace();
      snd_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      rcv_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
   endtask

   task automatic pick_setup(int unsigned max_dim);
      logic [VALUE_W-1:0] nv;
      case ($urandom_range(0, 3))
         0:       nv = '0;
         1:       nv = '1;
         default: nv = $urandom;
      endcase
      write_reg(CSR_NULL_VALUE, nv);
      case ($urandom_range(0, 5))
         0:       write_reg(CSR_TRIM_AMOUNT, 0);
         1:       write_reg(CSR_TRIM_AMOUNT, 256);
         default: write_reg(CSR_TRIM_AMOUNT, $urandom_range(1, max_dim));
      endcase
      write_reg(CSR_FRAME_ROWS, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_dim));
      write_reg(CSR_FRAME_COLS, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_dim));
      end_writes();
      if (frame_size() < 2) begin
         write_reg(CSR_FRAME_COLS, 2);
         end_writes();
      end
   endtask

   // Shrink one dimension part-way through a readout, then read out the rest.
   task automatic cut_readout(csr_idx_type idx, int unsigned lo, int unsigned hi);
      write_reg(idx, $urandom_range(lo, hi));
      end_writes();
      push_fetches((rd_idx + 1 >= frame_size()) ? 1 : frame_size() - rd_idx);
      drain();
   endtask

   task automatic long_frame(bit tall);
      write_reg(CSR_NULL_VALUE, $urandom);
      write_reg(CSR_TRIM_AMOUNT, $urandom_range(0, 256));
      write_reg(CSR_FRAME_ROWS, tall ? 300 : 1);
      write_reg(CSR_FRAME_COLS, tall ? 0 : 256);
      end_writes();
      // keep offering fetches while the receiver holds off, so the block backs up
      snd_max = 0;
      rcv_max = 0;
      hold_go = 1'b1;
      push_loads(256);
      push_fetches(20);
      drain();
      hold_go = 1'b0;
      pick_pace();
      cut_readout(tall ? CSR_FRAME_ROWS : CSR_FRAME_COLS, 21, 40);
   endtask

   initial begin
      int unsigned iter;
      int unsigned k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single pixel, zero trim: the trailing edge still nulls the set pixel
      write_reg(CSR_NULL_VALUE, 32'h0000_0000);
      write_reg(CSR_TRIM_AMOUNT, 0);
      write_reg(CSR_FRAME_ROWS, 1);
      write_reg(CSR_FRAME_COLS, 1);
      end_writes();
      push_word(MODE_FETCH, 32'hFFFF_FFFF);
      push_word(MODE_LOAD, 32'hFFFF_FFFF);
      push_word(MODE_LOAD, 32'h0000_0000);
      push_word(MODE_FETCH, 32'h0000_0000);
      drain();

      // all-ones null word with a trim far beyond the frame edge
      write_reg(CSR_NULL_VALUE, 32'hFFFF_FFFF);
      write_reg(CSR_TRIM_AMOUNT, 256);
      write_reg(CSR_FRAME_ROWS, 2);
      write_reg(CSR_FRAME_COLS, 3);
      end_writes();
      push_word(MODE_LOAD, 32'h0000_0000);
      push_word(MODE_LOAD, 32'hFFFF_FFFF);
      push_word(MODE_LOAD, 32'h7FFF_FFFF);
      push_word(MODE_LOAD, 32'hFFFF_FFFE);
      push_word(MODE_LOAD, 32'h8000_0000);
      push_word(MODE_LOAD, 32'hFFFF_FFFF);
      push_fetches(6);
      drain();

      write_reg(CSR_NULL_VALUE, 32'h5A5A_A5A5);
      write_reg(CSR_TRIM_AMOUNT, 1);
      write_reg(CSR_FRAME_ROWS, 2);
      write_reg(CSR_FRAME_COLS, 2);
      end_writes();
      push_word(MODE_LOAD, 32'h5A5A_A5A5);
      push_word(MODE_LOAD, 32'h0000_0001);
      push_word(MODE_LOAD, 32'h5A5A_A5A4);
      push_word(MODE_LOAD, 32'h5A5A_A5A5);
      push_fetches(4);
      drain();

      iter = 0;
      while (words_sent < 750) begin
         iter++;
         pick_pace();
         if (iter == 2 || iter == 5) begin
            long_frame(iter == 5);
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  // change one dimension part-way through loading
                  pick_setup(6);
                  k = $urandom_range(1, frame_size() - 1);
                  push_loads(k);
                  drain();
                  if ($urandom_range(0, 1)) write_reg(CSR_FRAME_ROWS, $urandom_range(0, 6));
                  else write_reg(CSR_FRAME_COLS, $urandom_range(0, 6));
                  end_writes();
                  push_loads((ld_idx >= frame_size()) ? 1 : frame_size() - ld_idx);
                  push_fetches(frame_size());
                  drain();
               end
               1: begin
                  pick_setup(6);
                  push_loads(frame_size());
                  push_fetches($urandom_range(1, frame_size() - 1));
                  drain();
                  if ($urandom_range(0, 1))
                     cut_readout(CSR_FRAME_ROWS, 1, dim_in_use(rows_reg));
                  else
                     cut_readout(CSR_FRAME_COLS, 1, dim_in_use(cols_reg));
               end
               default: begin
                  pick_setup(6);
                  if ($urandom_range(0, 3) == 0) push_word(MODE_FETCH, $urandom);
                  push_loads(frame_size());
                  if ($urandom_range(0, 3) == 0) push_word(MODE_LOAD, $urandom);
                  push_fetches(frame_size());
                  if ($urandom_range(0, 3) == 0) push_word(MODE_FETCH, $urandom);
                  drain();
               end
            endcase
         end
      end

      drain();
      if (err_count == 0 && trimmed_q.size() == 0) begin
         $display("mask_edge_trim regression: pass");
      end else begin
         $display("mask_edge_trim regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("mask_edge_trim regression: fail");
      $finish;
   end

endmodule
